[rtl/biquad_tdf2_filter_unit_assert.svh]
// ----------------------------------------------------------------------------
// biquad_tdf2_filter_unit_assert.svh
// Assertion macros for the biquad filter checker.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_TDF2_FILTER_UNIT_ASSERT_SVH
`define BIQUAD_TDF2_FILTER_UNIT_ASSERT_SVH

// Clocked assertion, switched off while reset is high
`define BQD_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Clocked assertion that also holds across reset
`define BQD_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

[rtl/bqd_pkg.sv]
// ----------------------------------------------------------------------------
// bqd_pkg
// Widths, register indexes, controller states and saturation helpers for the
// biquad filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bqd_pkg;

   // Fixed field and datapath widths
   localparam int SAMPLE_W  = 24;   // Q1.23 sample
   localparam int STATE_W   = 32;   // Q9.23 delay state and internal y
   localparam int PROD_W    = 34;   // rounded coefficient product
   localparam int SUM_W     = 36;   // sum of rounded terms before saturation
   localparam int CSR_IDX_W = 3;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] REG_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A2 = 3'd4;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,   // wait for an input word
      ST_MULX,   // b0, b1, b2 times x
      ST_SUMY,   // y ready, launch feedback products
      ST_MULY,   // a1, a2 times y
      ST_SUMN,   // form new state values
      ST_WB      // write state back, hand word to output register
   } bqd_state_type;

   // Clamp a wide sum to the 32-bit state range
   function automatic logic signed [STATE_W-1:0] sat_state(
      input logic signed [SUM_W-1:0] v
   );
      logic [SUM_W-STATE_W:0] top;
      logic signed [STATE_W-1:0] res;
      top = v[SUM_W-1:STATE_W-1];
      if ((top == '0) || (top == '1)) begin
         res = v[STATE_W-1:0];
      end else if (v[SUM_W-1]) begin
         res = {1'b1, {(STATE_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(STATE_W-1){1'b1}}};
      end
      return res;
   endfunction

   // Clamp a state-width value to the 24-bit sample range
   function automatic logic signed [SAMPLE_W-1:0] sat_sample(
      input logic signed [STATE_W-1:0] v
   );
      logic [STATE_W-SAMPLE_W:0] top;
      logic signed [SAMPLE_W-1:0] res;
      top = v[STATE_W-1:SAMPLE_W-1];
      if ((top == '0) || (top == '1)) begin
         res = v[SAMPLE_W-1:0];
      end else if (v[STATE_W-1]) begin
         res = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

[rtl/bqd_digit_mul.sv]
// ----------------------------------------------------------------------------
// bqd_digit_mul
// Radix-4 digit-serial signed multiplier. Consumes two coefficient bits per
// cycle, least significant first, and shifts two product bits out of a narrow
// accumulator each step; then rounds half up to the multiplicand's LSB.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bqd_digit_mul #(
   parameter int COEFF_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [bqd_pkg::STATE_W-1:0]    mcand,
   input  logic signed [COEFF_WIDTH-1:0]         coef,
   output logic                                  done,
   output logic signed [bqd_pkg::PROD_W-1:0]     product
);

   import bqd_pkg::*;

   localparam int CWE     = COEFF_WIDTH + (COEFF_WIDTH % 2);
   localparam int NDIG    = CWE / 2;
   localparam int CNT_W   = $clog2(NDIG + 1);
   localparam int ACC_W   = STATE_W + 3;
   localparam int FULL_W  = ACC_W + CWE;
   localparam int RND_POS = COEFF_WIDTH - 3;
   localparam int SHR     = COEFF_WIDTH - 2;

   logic signed [STATE_W-1:0] mcand_ff;
   logic signed [STATE_W+1:0] m3_ff;
   logic [CWE-1:0]            coef_sr_ff, coef_sr_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [CWE-1:0]            low_ff, low_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;

   logic signed [ACC_W-1:0]   m1, m2, m3, mult, tsum;
   logic                      last_dig;
   logic [FULL_W-1:0]         full_prod;

   // Multiples of the multiplicand for one radix-4 digit
   assign m1       = ACC_W'(mcand_ff);
   assign m2       = m1 <<< 1;
   assign m3       = ACC_W'(m3_ff);
   assign last_dig = (cnt_ff == CNT_W'(1));

   // Select the multiple; the top digit carries the negative sign weight
   always_comb begin
      unique case ({last_dig, coef_sr_ff[1:0]})
         3'b000:  mult = '0;
         3'b001:  mult = m1;
         3'b010:  mult = m2;
         3'b011:  mult = m3;
         3'b100:  mult = '0;
         3'b101:  mult = m1;
         3'b110:  mult = -m2;
         3'b111:  mult = -m1;
         default: mult = '0;
      endcase
   end

   assign tsum      = acc_ff + mult;
   assign full_prod = {acc_ff, low_ff};

   // Step, round and load control
   always_comb begin
      coef_sr_in = coef_sr_ff;
      acc_in     = acc_ff;
      low_in     = low_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;
      prod_in    = prod_ff;
      if (start) begin
         coef_sr_in = CWE'(coef);
         acc_in     = '0;
         cnt_in     = CNT_W'(NDIG);
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            // Add the digit's multiple, shift two finished bits out
            coef_sr_in = coef_sr_ff >> 2;
            acc_in     = tsum >>> 2;
            low_in     = {tsum[1:0], low_ff[CWE-1:2]};
            cnt_in     = cnt_ff - CNT_W'(1);
         end else begin
            // Round half up: drop SHR bits, add the highest dropped bit
            prod_in = signed'(full_prod[SHR +: PROD_W])
                    + signed'(PROD_W'(full_prod[RND_POS]));
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (start) begin
         mcand_ff <= mcand;
         m3_ff    <= (STATE_W+2)'(mcand) + ((STATE_W+2)'(mcand) <<< 1);
      end
      coef_sr_ff <= coef_sr_in;
      acc_ff     <= acc_in;
      low_ff     <= low_in;
      prod_ff    <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule

[rtl/biquad_tdf2_filter_unit.sv]
// ----------------------------------------------------------------------------
// biquad_tdf2_filter_unit: second-order IIR section, transposed direct form II
// Each word runs two passes of the radix-4 serial multipliers: b*x, then a*y.
// A new input word is accepted only after the last one is written back.
// Reset (synchronous): clears coefficients, channel state and handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module biquad_tdf2_filter_unit #(
   parameter int CHANNELS    = 2,
   parameter int COEFF_WIDTH = 24
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,   // [23:0] sample_in
   input  logic [0:0]                        req_tuser,   // [0] channel_in
   // Result stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,   // [23:0] sample_out
   output logic [0:0]                        rsp_tuser,   // [0] channel_out
   // Coefficient writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bqd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [COEFF_WIDTH-1:0]            csr_data
);

   import bqd_pkg::*;

   localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   bqd_state_type state_ff, state_in;

   logic signed [COEFF_WIDTH-1:0] coef_b0_ff, coef_b1_ff, coef_b2_ff;
   logic signed [COEFF_WIDTH-1:0] coef_a1_ff, coef_a2_ff;
   logic signed [STATE_W-1:0]     delay_one_ff [CHANNELS];
   logic signed [STATE_W-1:0]     delay_two_ff [CHANNELS];

   logic                          ch_ff, chv_ff;
   logic signed [STATE_W-1:0]     s1_ff, s2_ff, y_ff, n1_ff, n2_ff;
   logic signed [SUM_W-1:0]       n1p_ff;
   logic signed [PROD_W-1:0]      rb2_ff;
   logic                          rsp_valid_ff;
   logic [SAMPLE_W-1:0]           rsp_data_ff;
   logic                          rsp_chan_ff;

   logic                          accept, start_y, load_y, load_n, wb_fire;
   logic                          in_chv;
   logic [CH_W-1:0]               in_idx, ch_idx;
   logic signed [SAMPLE_W-1:0]    x_in;
   logic signed [STATE_W-1:0]     x_ext, mcand_fb;
   logic signed [COEFF_WIDTH-1:0] coef_u1, coef_u2;
   logic                          done0, done1, done2;
   logic signed [PROD_W-1:0]      prod0, prod1, prod2;

   // Input decode
   assign x_in   = signed'(req_tdata[SAMPLE_W-1:0]);
   assign x_ext  = STATE_W'(x_in);
   assign in_chv = ({31'd0, req_tuser[0]} < 32'(CHANNELS));
   assign in_idx = CH_W'(req_tuser[0]);
   assign ch_idx = CH_W'(ch_ff);

   // Sequencer: next state and strobes
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      accept     = 1'b0;
      start_y    = 1'b0;
      load_y     = 1'b0;
      load_n     = 1'b0;
      wb_fire    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               accept   = 1'b1;
               state_in = ST_MULX;
            end
         end
         ST_MULX: begin
            if (done0) begin
               load_y   = 1'b1;
               state_in = ST_SUMY;
            end
         end
         ST_SUMY: begin
            start_y  = 1'b1;
            state_in = ST_MULY;
         end
         ST_MULY: begin
            if (done1 && done2) begin
               load_n   = 1'b1;
               state_in = ST_SUMN;
            end
         end
         ST_SUMN: begin
            state_in = ST_WB;
         end
         ST_WB: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               wb_fire  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Feedforward multiplier for b0
   bqd_digit_mul #(.COEFF_WIDTH(COEFF_WIDTH)) u_mul0 (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .mcand   (x_ext),
      .coef    (coef_b0_ff),
      .done    (done0),
      .product (prod0)
   );

   // Shared units: b1/b2 times x, then a1/a2 times y
   assign mcand_fb = start_y ? y_ff : x_ext;
   assign coef_u1  = start_y ? coef_a1_ff : coef_b1_ff;
   assign coef_u2  = start_y ? coef_a2_ff : coef_b2_ff;

   bqd_digit_mul #(.COEFF_WIDTH(COEFF_WIDTH)) u_mul1 (
      .clock   (clock),
      .reset   (reset),
      .start   (accept | start_y),
      .mcand   (mcand_fb),
      .coef    (coef_u1),
      .done    (done1),
      .product (prod1)
   );

   bqd_digit_mul #(.COEFF_WIDTH(COEFF_WIDTH)) u_mul2 (
      .clock   (clock),
      .reset   (reset),
      .start   (accept | start_y),
      .mcand   (mcand_fb),
      .coef    (coef_u2),
      .done    (done2),
      .product (prod2)
   );

   // Coefficient registers, channel state and output handshake
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff   <= '0;
         coef_b1_ff   <= '0;
         coef_b2_ff   <= '0;
         coef_a1_ff   <= '0;
         coef_a2_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            delay_one_ff[i] <= '0;
            delay_two_ff[i] <= '0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_B0:  coef_b0_ff <= csr_data;
               REG_B1:  coef_b1_ff <= csr_data;
               REG_B2:  coef_b2_ff <= csr_data;
               REG_A1:  coef_a1_ff <= csr_data;
               REG_A2:  coef_a2_ff <= csr_data;
               default: ;
            endcase
         end
         // Commit the new state for a channel in range
         if (wb_fire && chv_ff) begin
            delay_one_ff[ch_idx] <= n1_ff;
            delay_two_ff[ch_idx] <= n2_ff;
         end
         if (wb_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         // Channel out of range runs on zero state
         ch_ff  <= req_tuser[0];
         chv_ff <= in_chv;
         s1_ff  <= in_chv ? delay_one_ff[in_idx] : '0;
         s2_ff  <= in_chv ? delay_two_ff[in_idx] : '0;
      end
      if (load_y) begin
         y_ff   <= sat_state(SUM_W'(prod0) + SUM_W'(s1_ff));
         n1p_ff <= SUM_W'(prod1) + SUM_W'(s2_ff);
         rb2_ff <= prod2;
      end
      if (load_n) begin
         n1_ff <= sat_state(n1p_ff - SUM_W'(prod1));
         n2_ff <= sat_state(SUM_W'(rb2_ff) - SUM_W'(prod2));
      end
      if (wb_fire) begin
         rsp_data_ff <= sat_sample(y_ff);
         rsp_chan_ff <= ch_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_chan_ff;
   assign csr_ready  = 1'b1;

endmodule

[rtl/bqd_checker.sv]
// ----------------------------------------------------------------------------
// bqd_checker
// Port-level checks on the biquad filter: one word in flight, result timing
// against the input side, output stability and reset state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "biquad_tdf2_filter_unit_assert.svh"

module bqd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bqd_pkg::SAMPLE_W-1:0]    rsp_tdata,
   input logic [0:0]                      rsp_tuser
);

   // Output register is empty right after reset
   `BQD_ASSERT_ALWAYS(a_rst_empty, clock, $past(reset) |-> !rsp_tvalid, "rsp_tvalid after reset")

   // Only one word is in flight: ready drops after an accept
   `BQD_ASSERT(a_one_item, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "second word taken while busy")

   // A fresh result is loaded only while the input side is closed
   `BQD_ASSERT(a_rsp_rise, clock, reset, $rose(rsp_tvalid) |-> !$past(req_tready), "result appeared while idle")

   // A stalled result holds its word
   `BQD_ASSERT(a_rsp_hold, clock, reset, (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)), "stalled result changed")

endmodule

bind biquad_tdf2_filter_unit bqd_checker u_bqd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/biquad_tdf2_filter_unit_tb.sv]
// ----------------------------------------------------------------------------
// biquad_tdf2_filter_unit_tb
// Self-checking bench for the biquad filter unit. Words are streamed with
// random gaps on both sides. Each accepted input runs through a transposed
// direct form II predictor that keeps its own coefficients and its own
// per-channel state. Each output word is compared with the oldest prediction.
// Coefficient sets change between phases: reset values, extremes, a fixed
// lowpass, random stable sections and unbounded random ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module biquad_tdf2_filter_unit_tb;
   import bqd_pkg::*;

   localparam int CHANNELS     = 2;
   localparam int COEFF_WIDTH  = 24;
   localparam int NUM_COEFS    = REG_A2 + 1;
   localparam int LAST_INDEX   = (1 << CSR_IDX_W) - 1;
   localparam int PHASES       = 9;
   localparam int PHASE_WORDS  = 200;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 64;

   localparam logic [SAMPLE_W-1:0]    SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0]    SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [COEFF_WIDTH-1:0] COEF_MAX   = {1'b0, {(COEFF_WIDTH-1){1'b1}}};
   localparam logic [COEFF_WIDTH-1:0] COEF_MIN   = {1'b1, {(COEFF_WIDTH-1){1'b0}}};

   typedef enum int {
      SET_LOWPASS,
      SET_STABLE,
      SET_WILD,
      SET_EXTREME
   } coef_set_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] audio;
      logic [0:0]          chan;
   } filter_word_type;

   // ------------------------------------------------------------------------
   // Filter predictor and expected output store
   // ------------------------------------------------------------------------
   class filter_scoreboard;
      longint          coef[NUM_COEFS];
      longint          z1[CHANNELS];
      longint          z2[CHANNELS];
      filter_word_type expected_words[$];
      int              error_count;

      function new();
         foreach (coef[i]) coef[i] = 0;
         foreach (z1[i]) begin
            z1[i] = 0;
            z2[i] = 0;
         end
         error_count = 0;
      endfunction

      // Coefficient times operand, rounded half up back to the operand LSB
      function longint round_product(longint c, longint v);
         return (c * v + (longint'(1) << (COEFF_WIDTH - 3))) >>> (COEFF_WIDTH - 2);
      endfunction

      function longint clamp(longint v, int w);
         longint hi;
         longint lo;
         hi = (longint'(1) << (w - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      // Indexes past the last coefficient are dropped
      function void write_coef(logic [CSR_IDX_W-1:0] idx, logic [COEFF_WIDTH-1:0] value);
         if (idx <= REG_A2) coef[idx] = longint'(signed'(value));
      endfunction

      function void note_sample(logic [SAMPLE_W-1:0] audio, logic [0:0] chan);
         longint          x;
         longint          y;
         longint          s1;
         longint          s2;
         longint          n1;
         longint          n2;
         bit              known;
         filter_word_type w;
         x     = longint'(signed'(audio));
         known = (int'(chan) < CHANNELS);
         s1    = known ? z1[chan] : 0;
         s2    = known ? z2[chan] : 0;
         y  = clamp(round_product(coef[REG_B0], x) + s1, STATE_W);
         n1 = clamp(round_product(coef[REG_B1], x) - round_product(coef[REG_A1], y) + s2,
                    STATE_W);
         n2 = clamp(round_product(coef[REG_B2], x) - round_product(coef[REG_A2], y),
                    STATE_W);
         // Advance the channel state
         if (known) begin
            z1[chan] = n1;
            z2[chan] = n2;
         end
         w.audio = SAMPLE_W'(clamp(y, SAMPLE_W));
         w.chan  = chan;
         expected_words.push_back(w);
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $realtime, msg);
         error_count++;
      endtask

      task check_result(logic [SAMPLE_W-1:0] audio, logic [0:0] chan);
         filter_word_type w;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word audio=%h chan=%0d", audio, chan));
         end else begin
            w = expected_words.pop_front();
            if (audio !== w.audio)
               report_mismatch($sformatf("audio got %h want %h", audio, w.audio));
            if (chan !== w.chan)
               report_mismatch($sformatf("chan got %0d want %0d", chan, w.chan));
         end
      endtask
   endclass

   // ------------------------------------------------------------------------
   // Clock, reset and DUT
   // ------------------------------------------------------------------------
   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_W-1:0]    req_tdata   = '0;
   logic [0:0]             req_tuser   = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [SAMPLE_W-1:0]    rsp_tdata;
   logic [0:0]             rsp_tuser;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index   = '0;
   logic [COEFF_WIDTH-1:0] csr_data    = '0;

   int send_idle_pct = 29;
   int recv_idle_pct = 78;
   int quiet_cycles  = 0;

   filter_scoreboard sb = new();

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   biquad_tdf2_filter_unit #(
      .CHANNELS    (CHANNELS),
      .COEFF_WIDTH (COEFF_WIDTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Check each output word and throttle the receiver
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Drop the run when nothing moves for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------
   task automatic send_sample(input logic [SAMPLE_W-1:0] audio, input logic [0:0] chan);
      int gap;
      // Idle the sender, now and then for a long stretch
      while ($urandom_range(99) < send_idle_pct) begin
         gap = ($urandom_range(19) == 0) ? $urandom_range(2, 60) : 1;
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= audio;
      req_tuser  <= chan;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_sample(audio, chan);
   endtask

   // Hold the sender until every expected word is back
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [COEFF_WIDTH-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.write_coef(idx, value);
   endtask

   // Write all five coefficients, then a stray index that must not land anywhere
   task automatic load_coefs(input logic [COEFF_WIDTH-1:0] b0, input logic [COEFF_WIDTH-1:0] b1,
                             input logic [COEFF_WIDTH-1:0] b2, input logic [COEFF_WIDTH-1:0] a1,
                             input logic [COEFF_WIDTH-1:0] a2);
      csr_write(REG_B0, b0);
      csr_write(REG_B1, b1);
      csr_write(REG_B2, b2);
      csr_write(REG_A1, a1);
      csr_write(REG_A2, a2);
      csr_write(CSR_IDX_W'($urandom_range(int'(REG_A2) + 1, LAST_INDEX)),
                COEFF_WIDTH'($urandom));
      csr_valid <= 1'b0;
   endtask

   function automatic logic [COEFF_WIDTH-1:0] pick_extreme();
      unique case ($urandom_range(2))
         0:       return COEF_MIN;
         1:       return COEF_MAX;
         default: return '0;
      endcase
   endfunction

   task automatic program_filter(input coef_set_type kind);
      int a1;
      int a2;
      int lim;
      unique case (kind)
         // 0.25, 0.5, 0.25 over 1 - 1.1 z^-1 + 0.4 z^-2
         SET_LOWPASS: load_coefs(COEFF_WIDTH'(1048576), COEFF_WIDTH'(2097152),
                                 COEFF_WIDTH'(1048576), COEFF_WIDTH'(-4613734),
                                 COEFF_WIDTH'(1677722));
         SET_STABLE: begin
            a2  = $urandom_range(0, 3774873);
            lim = (4194304 + a2) * 9 / 10;
            a1  = int'($urandom_range(0, 2 * lim)) - lim;
            load_coefs(COEFF_WIDTH'(int'($urandom_range(0, 1 << 22)) - (1 << 21)),
                       COEFF_WIDTH'(int'($urandom_range(0, 1 << 22)) - (1 << 21)),
                       COEFF_WIDTH'(int'($urandom_range(0, 1 << 22)) - (1 << 21)),
                       COEFF_WIDTH'(a1), COEFF_WIDTH'(a2));
         end
         SET_WILD: load_coefs(COEFF_WIDTH'($urandom), COEFF_WIDTH'($urandom),
                              COEFF_WIDTH'($urandom), COEFF_WIDTH'($urandom),
                              COEFF_WIDTH'($urandom));
         default: load_coefs(pick_extreme(), pick_extreme(), pick_extreme(),
                             pick_extreme(), pick_extreme());
      endcase
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_audio();
      unique case ($urandom_range(9))
         0, 1, 2, 3, 4: return SAMPLE_W'($urandom);
         5, 6, 7:       return SAMPLE_W'(int'($urandom_range(0, 1 << 17)) - (1 << 16));
         8:             return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         default:       return '0;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Coefficients out of reset are zero, so these come back silent
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample('1, 1'b0);
      wait_until_drained();

      // Extreme gains: output clips, then state runs into its own limits
      load_coefs(COEF_MAX, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX);
      send_sample(SAMPLE_MAX, 1'b0);
      send_sample(SAMPLE_MIN, 1'b1);
      send_sample('0, 1'b0);
      send_sample(SAMPLE_W'(1), 1'b1);
      send_sample('1, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);
      repeat (6) send_sample(SAMPLE_MAX, 1'b0);
      repeat (3) send_sample(SAMPLE_MIN, 1'b1);
      wait_until_drained();

      load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN);
      send_sample(SAMPLE_MAX, 1'b1);
      send_sample(SAMPLE_MIN, 1'b0);
      send_sample(SAMPLE_MAX, 1'b1);

      // Random phases: idle mixes change every three phases
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_until_drained();
         if (phase < 3) begin
            send_idle_pct <= 29;
            recv_idle_pct <= 78;
         end else if (phase < 6) begin
            send_idle_pct <= 78;
            recv_idle_pct <= 29;
         end else begin
            send_idle_pct <= 0;
            recv_idle_pct <= 0;
         end
         program_filter(coef_set_type'(phase % 4));
         for (int i = 0; i < PHASE_WORDS; i++) begin
            if ($urandom_range(199) == 0) wait_until_drained();
            send_sample(pick_audio(), 1'($urandom_range(1)));
         end
      end

      wait_until_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
